### hw/rtl/nrmc_pkg.sv
// Package for the NMEA RMC position parser: constants, character codes,
// record types and the small arithmetic helpers shared by the RTL files.
// No dependencies.
package nrmc_pkg;

    // Sentence limits and fixed-point scaling.
    localparam int MAX_BODY_LEN = 80;
    localparam int FRAC_DIGITS  = 5;

    // Widths of the parser state and of the result fields.
    localparam int BODY_W     = 7;
    localparam int FIELD_W    = 4;
    localparam int HDR_W      = 3;
    localparam int FRAC_W     = 3;
    localparam int LAT_W      = 30;
    localparam int LON_W      = 34;
    localparam int LAT_OUT_W  = 31;
    localparam int LON_OUT_W  = 35;
    localparam int POW_W      = $clog2(10 ** FRAC_DIGITS + 1);
    localparam int LAT_PROD_W = LAT_W + POW_W;
    localparam int LON_PROD_W = LON_W + POW_W;

    // Saturation limits of the magnitudes.
    localparam logic [LAT_W-1:0] LAT_MAX = 30'd999999999;
    localparam logic [LON_W-1:0] LON_MAX = 34'd9999999999;

    // Header length and ASCII codes.
    localparam logic [HDR_W-1:0] HDR_LEN = 3'd7;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Body field positions.
    localparam logic [FIELD_W-1:0] FLD_STATUS   = 4'd1;
    localparam logic [FIELD_W-1:0] FLD_LAT      = 4'd2;
    localparam logic [FIELD_W-1:0] FLD_LAT_HEMI = 4'd3;
    localparam logic [FIELD_W-1:0] FLD_LON      = 4'd4;
    localparam logic [FIELD_W-1:0] FLD_LON_HEMI = 4'd5;
    localparam logic [FIELD_W-1:0] FLD_LAST     = 4'd15;

    // Finished sentence handed from the parser to the scaling pipeline.
    typedef struct packed {
        logic              status_ok;
        logic [LAT_W-1:0]  lat_acc;
        logic [FRAC_W-1:0] lat_frac;
        logic              lat_neg;
        logic [LON_W-1:0]  lon_acc;
        logic [FRAC_W-1:0] lon_frac;
        logic              lon_neg;
    } snap_t;

    // Running state of one numeric field.
    typedef struct packed {
        logic [LON_W-1:0]  acc;
        logic [FRAC_W-1:0] frac;
        logic              point_seen;
        logic              stopped;
    } num_t;

    // Expected header character at each match position.
    function automatic logic [7:0] hdr_char(input logic [HDR_W-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_DOLLAR;
            3'd1:    ch = CH_G;
            3'd2:    ch = CH_P;
            3'd3:    ch = CH_R;
            3'd4:    ch = CH_M;
            3'd5:    ch = CH_C;
            3'd6:    ch = CH_COMMA;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Multiply by ten, add a digit and saturate at the given limit.
    function automatic logic [LON_W-1:0] push_digit(input logic [LON_W-1:0] acc,
                                                    input logic [3:0]       d,
                                                    input logic [LON_W-1:0] max);
        logic [LON_W+3:0] wide;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {LON_W'(0), d};
        return (wide > {4'b0, max}) ? max : wide[LON_W-1:0];
    endfunction

    // One character of a ddmm.mmmm number: digits and one point, the first
    // other character stops the number for the rest of the field.
    function automatic num_t number_step(input num_t             n,
                                         input logic [7:0]       c,
                                         input logic [LON_W-1:0] max);
        num_t r;
        r = n;
        if (!n.stopped)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (!n.point_seen)
                begin
                    r.acc = push_digit(n.acc, c[3:0], max);
                end
                else if (n.frac < FRAC_W'(FRAC_DIGITS))
                begin
                    r.frac = n.frac + 1'b1;
                    r.acc  = push_digit(n.acc, c[3:0], max);
                end
            end
            else if (c == CH_POINT && !n.point_seen)
            begin
                r.point_seen = 1'b1;
            end
            else
            begin
                r.stopped = 1'b1;
            end
        end
        return r;
    endfunction

    // Power of ten for the missing fraction digits.
    function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
        logic [POW_W-1:0] p;
        p = POW_W'(1);
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            if (FRAC_W'(i) < k)
            begin
                p = POW_W'(p * 10);
            end
        end
        return p;
    endfunction

endpackage

### hw/rtl/nrmc_if.sv
// Channel interfaces of the NMEA RMC position parser: the received byte
// channel and the position result channel. Depends on nrmc_pkg.
interface nrmc_byte_if;
    import nrmc_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_result_if;
    import nrmc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        fix_valid;
    logic signed [LAT_OUT_W-1:0] latitude_fixed;
    logic signed [LON_OUT_W-1:0] longitude_fixed;

    modport source (output valid, output fix_valid, output latitude_fixed,
                    output longitude_fixed, input ready);
    modport sink (input valid, input fix_valid, input latitude_fixed,
                  input longitude_fixed, output ready);
endinterface

### hw/rtl/nmea_rmc_position_parser.sv
// NMEA RMC position parser top level. Takes one byte per cycle; no stall
// while the result path has room. After the edge that takes the closing
// '*', a result passes the sentence register, multiply and output stages.
// Up to three results queue in the pipeline before the byte input stalls.
// Reset (asynchronous, active low) empties the pipeline and restarts the
// header hunt. Depends on nrmc_pkg, nrmc_if, nrmc_parser and nrmc_scale.
module nmea_rmc_position_parser (
    input logic           clk,
    input logic           rst_n,
    nrmc_byte_if.sink     rx,
    nrmc_result_if.source res
);
    import nrmc_pkg::*;

    snap_t snap;
    logic  snap_valid;
    logic  snap_ready;

    // Byte parsing and sentence capture.
    nrmc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    // Fixed-point scaling and result register.
    nrmc_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .res        (res)
    );

endmodule

### hw/rtl/nrmc_parser.sv
// Byte parser: header hunt, field split and digit accumulation, one byte
// per cycle while the one-entry sentence register on its output can drain.
// Depends on nrmc_pkg and nrmc_if.
module nrmc_parser (
    input  logic            clk,
    input  logic            rst_n,
    nrmc_byte_if.sink       rx,
    output nrmc_pkg::snap_t snap,
    output logic            snap_valid,
    input  logic            snap_ready
);
    import nrmc_pkg::*;

    // Per-sentence parse state.
    typedef struct packed {
        logic [FIELD_W-1:0] field_index;
        logic [BODY_W-1:0]  body_count;
        logic               status_ok;
        logic [LAT_W-1:0]   lat_accum;
        logic [LON_W-1:0]   lon_accum;
        logic [FRAC_W-1:0]  lat_frac;
        logic [FRAC_W-1:0]  lon_frac;
        logic               point_seen;
        logic               number_stopped;
        logic               lat_negative;
        logic               lon_negative;
    } body_t;

    localparam body_t BODY_INIT = '{
        field_index:    '0,
        body_count:     '0,
        status_ok:      1'b0,
        lat_accum:      '0,
        lon_accum:      '0,
        lat_frac:       '0,
        lon_frac:       '0,
        point_seen:     1'b0,
        number_stopped: 1'b0,
        lat_negative:   1'b1,
        lon_negative:   1'b1
    };

    logic [HDR_W-1:0] header_pos_reg, header_pos_next;
    logic             in_body_reg, in_body_next;
    body_t            body_reg, body_next;
    logic             snap_valid_reg, snap_valid_next;
    snap_t            snap_reg;

    logic             accept;
    logic             load_snap;
    logic [7:0]       c;
    logic [HDR_W-1:0] hdr_step;
    num_t             num_in;
    num_t             num_out;

    assign c      = rx.rx_byte;
    assign accept = rx.valid && rx.ready;

    // Next parse state for the byte of this transaction.
    always_comb
    begin
        header_pos_next = header_pos_reg;
        in_body_next    = in_body_reg;
        body_next       = body_reg;
        load_snap       = 1'b0;
        hdr_step        = '0;
        num_in          = '0;
        num_out         = '0;

        if (accept)
        begin
            if (!in_body_reg)
            begin
                // Contiguous header match; a dollar restarts just after it.
                if (c == hdr_char(header_pos_reg))
                begin
                    hdr_step = header_pos_reg + 1'b1;
                end
                else
                begin
                    hdr_step = (c == CH_DOLLAR) ? HDR_W'(1) : HDR_W'(0);
                end
                header_pos_next = hdr_step;
                if (hdr_step == HDR_LEN)
                begin
                    header_pos_next = '0;
                    in_body_next    = 1'b1;
                    body_next       = BODY_INIT;
                end
            end
            else if (c == CH_DOLLAR)
            begin
                // A new sentence starts inside the body: abandon this one.
                in_body_next    = 1'b0;
                header_pos_next = HDR_W'(1);
                body_next       = BODY_INIT;
            end
            else if (body_reg.body_count >= BODY_W'(MAX_BODY_LEN))
            begin
                // Over-length body is dropped without a result.
                in_body_next = 1'b0;
                body_next    = BODY_INIT;
            end
            else if (c == CH_STAR)
            begin
                load_snap    = 1'b1;
                in_body_next = 1'b0;
                body_next    = BODY_INIT;
            end
            else
            begin
                body_next.body_count = body_reg.body_count + 1'b1;
                if (c == CH_COMMA)
                begin
                    if (body_reg.field_index != FLD_LAST)
                    begin
                        body_next.field_index = body_reg.field_index + 1'b1;
                    end
                    body_next.point_seen     = 1'b0;
                    body_next.number_stopped = 1'b0;
                end
                else
                begin
                    case (body_reg.field_index)
                        FLD_STATUS:
                        begin
                            body_next.status_ok  = !body_reg.point_seen && c == CH_A;
                            body_next.point_seen = 1'b1;
                        end
                        FLD_LAT:
                        begin
                            num_in  = '{acc: LON_W'(body_reg.lat_accum),
                                        frac: body_reg.lat_frac,
                                        point_seen: body_reg.point_seen,
                                        stopped: body_reg.number_stopped};
                            num_out = number_step(num_in, c, LON_W'(LAT_MAX));
                            body_next.lat_accum      = num_out.acc[LAT_W-1:0];
                            body_next.lat_frac       = num_out.frac;
                            body_next.point_seen     = num_out.point_seen;
                            body_next.number_stopped = num_out.stopped;
                        end
                        FLD_LAT_HEMI:
                        begin
                            body_next.lat_negative = !(!body_reg.point_seen && c == CH_N);
                            body_next.point_seen   = 1'b1;
                        end
                        FLD_LON:
                        begin
                            num_in  = '{acc: body_reg.lon_accum,
                                        frac: body_reg.lon_frac,
                                        point_seen: body_reg.point_seen,
                                        stopped: body_reg.number_stopped};
                            num_out = number_step(num_in, c, LON_MAX);
                            body_next.lon_accum      = num_out.acc;
                            body_next.lon_frac       = num_out.frac;
                            body_next.point_seen     = num_out.point_seen;
                            body_next.number_stopped = num_out.stopped;
                        end
                        FLD_LON_HEMI:
                        begin
                            body_next.lon_negative = !(!body_reg.point_seen && c == CH_E);
                            body_next.point_seen   = 1'b1;
                        end
                        default:
                        begin
                            body_next = body_next;
                        end
                    endcase
                end
            end
        end
    end

    // Sentence register occupancy.
    always_comb
    begin
        if (load_snap)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg <= '0;
            in_body_reg    <= 1'b0;
            body_reg       <= BODY_INIT;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            header_pos_reg <= header_pos_next;
            in_body_reg    <= in_body_next;
            body_reg       <= body_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Finished sentence payload; fraction counts are applied downstream.
    always_ff @(posedge clk)
    begin
        if (load_snap)
        begin
            snap_reg.status_ok <= body_reg.status_ok;
            snap_reg.lat_acc   <= body_reg.lat_accum;
            snap_reg.lat_frac  <= body_reg.lat_frac;
            snap_reg.lat_neg   <= body_reg.lat_negative;
            snap_reg.lon_acc   <= body_reg.lon_accum;
            snap_reg.lon_frac  <= body_reg.lon_frac;
            snap_reg.lon_neg   <= body_reg.lon_negative;
        end
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;
    assign rx.ready   = !snap_valid_reg || snap_ready;

`ifndef SYNTHESIS
    // Header matching is idle while a body is being parsed.
    a_hdr_idle_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> header_pos_reg == '0)
        else $error("header position nonzero inside a body");

    // The body byte count never passes the limit.
    a_body_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        body_reg.body_count <= BODY_W'(MAX_BODY_LEN))
        else $error("body count beyond limit");

    // A sentence result is only produced from inside a body.
    a_snap_from_body: assert property (@(posedge clk) disable iff (!rst_n)
        load_snap |-> in_body_reg && !in_body_next)
        else $error("sentence result outside a body");
`endif

endmodule

### hw/rtl/nrmc_scale.sv
// Scaling pipeline: multiplies each magnitude by the power of ten for its
// missing fraction digits, then saturates, signs, zeroes an invalid fix
// and holds the result. Depends on nrmc_pkg and nrmc_if.
module nrmc_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  nrmc_pkg::snap_t snap,
    input  logic            snap_valid,
    output logic            snap_ready,
    nrmc_result_if.source   res
);
    import nrmc_pkg::*;

    logic                        m_valid_reg;
    logic                        m_status_reg;
    logic                        m_lat_neg_reg;
    logic                        m_lon_neg_reg;
    logic [LAT_PROD_W-1:0]       m_lat_prod_reg;
    logic [LON_PROD_W-1:0]       m_lon_prod_reg;

    logic                        o_valid_reg;
    logic                        o_fix_reg;
    logic signed [LAT_OUT_W-1:0] o_lat_reg;
    logic signed [LON_OUT_W-1:0] o_lon_reg;

    logic                        out_adv;
    logic                        m_load;
    logic                        o_load;
    logic [LAT_PROD_W-1:0]       lat_prod;
    logic [LON_PROD_W-1:0]       lon_prod;
    logic [LAT_W-1:0]            lat_sat;
    logic [LON_W-1:0]            lon_sat;
    logic signed [LAT_OUT_W-1:0] lat_val;
    logic signed [LON_OUT_W-1:0] lon_val;

    // Handshake between the stages.
    assign out_adv    = !o_valid_reg || res.ready;
    assign snap_ready = !m_valid_reg || out_adv;
    assign m_load     = snap_valid && snap_ready;
    assign o_load     = m_valid_reg && out_adv;

    // Fraction padding as one multiply per magnitude.
    always_comb
    begin
        lat_prod = LAT_PROD_W'(snap.lat_acc)
                 * LAT_PROD_W'(pow10(FRAC_W'(FRAC_DIGITS) - snap.lat_frac));
        lon_prod = LON_PROD_W'(snap.lon_acc)
                 * LON_PROD_W'(pow10(FRAC_W'(FRAC_DIGITS) - snap.lon_frac));
    end

    // Saturate, apply the hemisphere sign, and zero an invalid fix.
    always_comb
    begin
        lat_sat = (m_lat_prod_reg > LAT_PROD_W'(LAT_MAX)) ? LAT_MAX
                                                          : m_lat_prod_reg[LAT_W-1:0];
        lon_sat = (m_lon_prod_reg > LON_PROD_W'(LON_MAX)) ? LON_MAX
                                                          : m_lon_prod_reg[LON_W-1:0];
        if (!m_status_reg)
        begin
            lat_val = '0;
            lon_val = '0;
        end
        else
        begin
            lat_val = m_lat_neg_reg ? -$signed({1'b0, lat_sat}) : $signed({1'b0, lat_sat});
            lon_val = m_lon_neg_reg ? -$signed({1'b0, lon_sat}) : $signed({1'b0, lon_sat});
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_ready)
            begin
                m_valid_reg <= snap_valid;
            end
            if (out_adv)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_status_reg   <= snap.status_ok;
            m_lat_neg_reg  <= snap.lat_neg;
            m_lon_neg_reg  <= snap.lon_neg;
            m_lat_prod_reg <= lat_prod;
            m_lon_prod_reg <= lon_prod;
        end
        if (o_load)
        begin
            o_fix_reg <= m_status_reg;
            o_lat_reg <= lat_val;
            o_lon_reg <= lon_val;
        end
    end

    assign res.valid           = o_valid_reg;
    assign res.fix_valid       = o_fix_reg;
    assign res.latitude_fixed  = o_lat_reg;
    assign res.longitude_fixed = o_lon_reg;

`ifndef SYNTHESIS
    // An invalid fix carries zero positions.
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_fix_reg |-> o_lat_reg == '0 && o_lon_reg == '0)
        else $error("nonzero position with invalid fix");

    // Latitude stays inside its saturation range.
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> o_lat_reg <= 31'sd999999999 && o_lat_reg >= -31'sd999999999)
        else $error("latitude outside range");

    // A stalled output holds the product stage behind it.
    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && o_valid_reg && !res.ready |=> m_valid_reg && $stable(m_lat_prod_reg))
        else $error("product stage lost during stall");
`endif

endmodule

### sim/nmea_rmc_position_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NMEA RMC position parser: directed and random
// sentences with random idling on both channels, checked against a scoreboard.
// Depends on nrmc_pkg, nrmc_if and the nmea_rmc_position_parser RTL.
module nmea_rmc_position_parser_tb;
    import nrmc_pkg::*;

    localparam int ITEM_TARGET  = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] HDR_TEXT [7] = '{CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C, CH_COMMA};

    // One expected position report.
    typedef struct {
        logic                 fix_valid;
        logic [LAT_OUT_W-1:0] latitude;
        logic [LON_OUT_W-1:0] longitude;
    } rmc_fix_t;

    // Sentence parser mirror plus the queue of position reports it predicts.
    class rmc_fix_scoreboard;
        rmc_fix_t          pending_fixes[$];
        int unsigned       predicted;
        int unsigned       checked;
        int unsigned       errors;
        logic [HDR_W-1:0]  hdr_pos;
        bit                in_body;
        logic [FIELD_W-1:0] field_idx;
        int unsigned       body_len;
        bit                status_ok;
        logic [LAT_W-1:0]  lat_mag;
        logic [LON_W-1:0]  lon_mag;
        int unsigned       frac_cnt;
        bit                point_seen;
        bit                num_stopped;
        bit                lat_neg;
        bit                lon_neg;

        function new();
            predicted = 0;
            checked   = 0;
            errors    = 0;
            go_hunting();
        endfunction

        function void clear_field();
            frac_cnt    = 0;
            point_seen  = 1'b0;
            num_stopped = 1'b0;
        endfunction

        function void open_body();
            in_body   = 1'b1;
            hdr_pos   = '0;
            field_idx = '0;
            body_len  = 0;
            status_ok = 1'b0;
            lat_mag   = '0;
            lon_mag   = '0;
            lat_neg   = 1'b1;
            lon_neg   = 1'b1;
            clear_field();
        endfunction

        function void go_hunting();
            open_body();
            in_body = 1'b0;
        endfunction

        function longint unsigned add_digit(longint unsigned acc, int unsigned d,
                                            longint unsigned lim);
            longint unsigned v;
            v = acc * 10 + d;
            return (v > lim) ? lim : v;
        endfunction

        // Pad the magnitude with zeros up to the full number of fraction digits.
        function void close_field();
            if (field_idx == FLD_LAT)
            begin
                for (int k = frac_cnt; k < FRAC_DIGITS; k++)
                begin
                    lat_mag = add_digit(lat_mag, 0, LAT_MAX);
                end
            end
            else if (field_idx == FLD_LON)
            begin
                for (int k = frac_cnt; k < FRAC_DIGITS; k++)
                begin
                    lon_mag = add_digit(lon_mag, 0, LON_MAX);
                end
            end
        endfunction

        // Digits and a single point; anything else freezes the number.
        function void feed_number(bit lon_field, logic [7:0] c);
            longint unsigned acc;
            longint unsigned lim;
            acc = lon_field ? lon_mag : lat_mag;
            lim = lon_field ? LON_MAX : LAT_MAX;
            if (!num_stopped)
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    if (!point_seen)
                    begin
                        acc = add_digit(acc, c - CH_ZERO, lim);
                    end
                    else if (frac_cnt < FRAC_DIGITS)
                    begin
                        frac_cnt++;
                        acc = add_digit(acc, c - CH_ZERO, lim);
                    end
                end
                else if (c == CH_POINT && !point_seen)
                begin
                    point_seen = 1'b1;
                end
                else
                begin
                    num_stopped = 1'b1;
                end
            end
            if (lon_field)
                lon_mag = acc;
            else
                lat_mag = acc;
        endfunction

        // Note one accepted byte and queue the report that a closing star causes.
        function void note_byte(logic [7:0] c);
            rmc_fix_t fix;
            if (!in_body)
            begin
                if (hdr_pos < HDR_LEN && c == HDR_TEXT[hdr_pos])
                    hdr_pos++;
                else
                    hdr_pos = (c == CH_DOLLAR) ? 1 : 0;
                if (hdr_pos >= HDR_LEN)
                    open_body();
                return;
            end
            if (c == CH_DOLLAR)
            begin
                go_hunting();
                hdr_pos = 1;
                return;
            end
            if (body_len >= MAX_BODY_LEN)
            begin
                go_hunting();
                return;
            end
            body_len++;
            if (c == CH_STAR)
            begin
                close_field();
                fix.fix_valid = status_ok;
                fix.latitude  = '0;
                fix.longitude = '0;
                if (status_ok)
                begin
                    fix.latitude  = {1'b0, lat_mag};
                    fix.longitude = {1'b0, lon_mag};
                    if (lat_neg)
                        fix.latitude = -fix.latitude;
                    if (lon_neg)
                        fix.longitude = -fix.longitude;
                end
                pending_fixes.push_back(fix);
                predicted++;
                go_hunting();
                return;
            end
            if (c == CH_COMMA)
            begin
                close_field();
                if (field_idx < FLD_LAST)
                    field_idx++;
                clear_field();
                return;
            end
            case (field_idx)
                FLD_STATUS:
                begin
                    status_ok  = !point_seen && c == CH_A;
                    point_seen = 1'b1;
                end
                FLD_LAT:
                    feed_number(1'b0, c);
                FLD_LAT_HEMI:
                begin
                    lat_neg    = !(!point_seen && c == CH_N);
                    point_seen = 1'b1;
                end
                FLD_LON:
                    feed_number(1'b1, c);
                FLD_LON_HEMI:
                begin
                    lon_neg    = !(!point_seen && c == CH_E);
                    point_seen = 1'b1;
                end
                default:
                    ;
            endcase
        endfunction

        // Compare one reported position with the oldest prediction.
        function void check_fix(logic fv, logic [LAT_OUT_W-1:0] lat,
                                logic [LON_OUT_W-1:0] lon);
            rmc_fix_t fix;
            if (pending_fixes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected position report fix=%0b lat=%0d lon=%0d",
                         $time, fv, $signed(lat), $signed(lon));
                return;
            end
            fix = pending_fixes.pop_front();
            checked++;
            if (fv !== fix.fix_valid)
            begin
                errors++;
                $display("%0t: fix_valid expected %0b actual %0b",
                         $time, fix.fix_valid, fv);
            end
            if (lat !== fix.latitude)
            begin
                errors++;
                $display("%0t: latitude_fixed expected %0d actual %0d",
                         $time, $signed(fix.latitude), $signed(lat));
            end
            if (lon !== fix.longitude)
            begin
                errors++;
                $display("%0t: longitude_fixed expected %0d actual %0d",
                         $time, $signed(fix.longitude), $signed(lon));
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    nrmc_byte_if       rx_if();
    nrmc_result_if     res_if();
    rmc_fix_scoreboard fixes;
    logic [7:0]        line_q[$];
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    int unsigned       bytes_sent;
    int unsigned       sentences_sent;
    int unsigned       cycle_count;

    nmea_rmc_position_parser u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, fixes.pending_fixes.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check each transaction, then stall at random.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            fixes.check_fix(res_if.fix_valid, res_if.latitude_fixed, res_if.longitude_fixed);
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Send one byte, idling at random beforehand.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        fixes.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
        line_q.delete();
        sentences_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    // Printable character that never delimits anything.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = $urandom_range(33, 126);
        if (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA)
            c = "Z";
        return c;
    endfunction

    task automatic add_digits(input int unsigned n);
        repeat (n)
            line_q.push_back(CH_ZERO + $urandom_range(9));
    endtask

    // Random ddmm.mmmm style number, sometimes too long or malformed.
    task automatic add_number(input int unsigned typ_int);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 8)
            add_digits($urandom_range(1, typ_int));
        else if (pick == 8)
            add_digits($urandom_range(typ_int + 1, 14));
        if ($urandom_range(9) < 8)
        begin
            line_q.push_back(CH_POINT);
            add_digits(($urandom_range(9) < 7) ? $urandom_range(0, FRAC_DIGITS) :
                       $urandom_range(FRAC_DIGITS + 1, 8));
        end
        if ($urandom_range(14) == 0)
        begin
            line_q.push_back(($urandom_range(1) == 0) ? CH_POINT : text_char());
            add_digits($urandom_range(0, 3));
        end
    endtask

    task automatic add_hemi(input logic [7:0] pos_ch, input logic [7:0] neg_ch);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            line_q.push_back(pos_ch);
        else if (pick < 8)
            line_q.push_back(neg_ch);
        else if (pick == 9)
        begin
            line_q.push_back(($urandom_range(1) == 0) ? pos_ch : text_char());
            line_q.push_back(($urandom_range(1) == 0) ? pos_ch : text_char());
        end
    endtask

    // Mostly well-formed RMC sentence with random content and occasional damage.
    task automatic build_sentence();
        int unsigned pick;
        add_text("$GPRMC,");
        if ($urandom_range(19) == 0)
            line_q[$urandom_range(6)] = text_char();
        add_digits($urandom_range(0, 10));
        add_text(",");
        pick = $urandom_range(9);
        if (pick < 7)
            line_q.push_back(CH_A);
        else if (pick == 7)
            add_text("V");
        else if (pick == 9)
        begin
            line_q.push_back(($urandom_range(1) == 0) ? CH_A : text_char());
            line_q.push_back(($urandom_range(1) == 0) ? CH_A : text_char());
        end
        add_text(",");
        add_number(4);
        add_text(",");
        add_hemi(CH_N, "S");
        add_text(",");
        add_number(5);
        add_text(",");
        add_hemi(CH_E, "W");
        if ($urandom_range(1) == 0)
            add_text(",022.4,084.4,230394,003.1,W");
        if ($urandom_range(9) == 0)
        begin
            add_text(",");
            repeat ($urandom_range(20, 70))
                line_q.push_back(text_char());
        end
        pick = $urandom_range(24);
        if (pick == 0)
            line_q.push_back(CH_DOLLAR);
        else if (pick != 1)
            line_q.push_back(CH_STAR);
        if ($urandom_range(9) < 7)
            add_text("4A\r\n");
        repeat (($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0)
            line_q.push_back($urandom_range(255));
        if ($urandom_range(24) == 0)
            line_q.insert($urandom_range(line_q.size() - 1), $urandom_range(255));
    endtask

    // Directed sentences: the common case, every special case and the extremes.
    task automatic run_directed();
        add_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
        send_line();
        add_text("$GPRMC,,V,4807.038,N,01131.000,E*");
        send_line();
        // Empty fields everywhere, then a status that is more than one character.
        add_text("$GPRMC,,A,,,,*$GPRMC,,AA,1,N,2,E*");
        send_line();
        // Saturated magnitudes with extra fraction digits, south and west.
        add_text("$GPRMC,1,A,99999999999.999999,S,999999999999.9999999,W*");
        send_line();
        add_text("$GPRMC,1,A,12.3456789,N,1.2.3,E,x,y,z*");
        send_line();
        // Non-numeric characters stop the numbers; doubled sign letters are negative.
        add_text("$GPRMC,,A,12-3,NN,+45,EE*$GPRMC,,A,.5,N,.,E*");
        send_line();
        // Broken and restarted headers, star outside a body.
        add_text("*GPRMC,$GP$GPRMX,$$GPRMC,,A,0,N,9,E*");
        send_line();
        // A dollar inside the body abandons the sentence.
        add_text("$GPRMC,,A,1,N$GPRMC,,A,3,N,4,E*");
        send_line();
        // Body of exactly the maximum length, then one byte too long.
        add_text("$GPRMC,,A,1,N,2,E,");
        repeat (MAX_BODY_LEN - 12)
            add_text("x");
        add_text("*$GPRMC,,A,1,N,2,E,");
        repeat (MAX_BODY_LEN - 11)
            add_text("x");
        add_text("*");
        send_line();
        // Field index saturation and all-zero / all-one bytes in and out of a body.
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        add_text("$GPRMC,");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h00);
        add_text(",A,5,N,6,E,,,,,,,,,,,,,,,,*");
        send_line();
    endtask

    // Stimulus and end of run.
    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        res_if.ready   = 1'b0;
        fixes          = new();
        bytes_sent     = 0;
        sentences_sent = 0;
        src_idle_pct   = 18;
        snk_idle_pct   = 67;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 67 : 0;
            snk_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 18 : 0;
            while (bytes_sent < (phase + 1) * ITEM_TARGET / 3)
            begin
                build_sentence();
                send_line();
            end
        end
        rx_if.valid <= 1'b0;

        while (fixes.pending_fixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d sentences under three idle patterns",
                 bytes_sent, sentences_sent);
        $display("checked %0d position reports, %0d mismatches", fixes.checked, fixes.errors);
        if (fixes.errors == 0 && fixes.pending_fixes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/nrmc_pkg.sv
hw/rtl/nrmc_if.sv
hw/rtl/nrmc_parser.sv
hw/rtl/nrmc_scale.sv
hw/rtl/nmea_rmc_position_parser.sv
sim/nmea_rmc_position_parser_tb.sv
